/* src/mvconv_pkg.sv */
// Shared types and constants for the multichannel valid-mode correlator.
`default_nettype none
package mvconv_pkg;
  localparam int CmdW = 2;
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_KERNEL = 2'd1;
  localparam logic [1:0] ST_POS = 2'd2;

  localparam logic [2:0] REG_CHANNELS = 3'd0;
  localparam logic [2:0] REG_IMAGE_ROWS = 3'd1;
  localparam logic [2:0] REG_IMAGE_COLS = 3'd2;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd3;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd4;
  localparam logic [2:0] REG_BIAS = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] channel;
    logic [5:0] row;
    logic [5:0] col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] sum;
    logic [1:0] status;
  } out_item_t;

  // Classified compute job handed from the front to the back.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] row;
    logic [5:0] col;
  } job_t;
endpackage
`default_nettype wire

/* src/mvconv_front.sv */
// Front end: register file, store write decoding and compute classification.
`default_nettype none
module mvconv_front #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_IMAGE_DIM = 64,
  parameter int MAX_KERNEL_DIM = 8
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_valid,
  input wire logic [2:0] cfg_index,
  input wire logic [31:0] cfg_data,
  input wire logic in_push,
  input wire mvconv_pkg::in_item_t in_item,
  input wire logic job_full,
  input wire logic store_busy,
  output logic full,
  output logic job_push,
  output mvconv_pkg::job_t job,
  output logic [4:0] nch,
  output logic [4:0] kr,
  output logic [4:0] kc,
  output logic signed [31:0] bias
);
  logic [2:0] channels;
  logic [6:0] image_rows, image_cols;
  logic [3:0] kernel_rows, kernel_cols;
  logic [10:0] ir, ic;
  logic take;
  logic is_write;

  function automatic logic [10:0] clamp(input logic [6:0] v, input int hi);
    logic [10:0] r;
    begin
      r = {4'd0, v};
      if (v == 7'd0) r = 11'd1;
      else if (int'(v) > hi) r = 11'(hi);
      return r;
    end
  endfunction

  assign nch = 5'(clamp({4'd0, channels}, MAX_CHANNELS));
  assign ir = clamp(image_rows, MAX_IMAGE_DIM);
  assign ic = clamp(image_cols, MAX_IMAGE_DIM);
  assign kr = 5'(clamp({3'd0, kernel_rows}, MAX_KERNEL_DIM));
  assign kc = 5'(clamp({3'd0, kernel_cols}, MAX_KERNEL_DIM));

  // A store write waits until every compute accepted before it has read the stores.
  assign is_write = in_item.command == mvconv_pkg::CMD_WEIGHT
                    || in_item.command == mvconv_pkg::CMD_SAMPLE;
  assign full = job_full || (store_busy && is_write);
  assign take = in_push && !full;
  assign job_push = take && in_item.command == mvconv_pkg::CMD_COMPUTE;

  always_comb begin
    job.row = in_item.row;
    job.col = in_item.col;
    if ({6'd0, kr} > ir || {6'd0, kc} > ic) begin
      job.status = mvconv_pkg::ST_KERNEL;
    end else if ({5'd0, in_item.row} > ir - {6'd0, kr}
                 || {5'd0, in_item.col} > ic - {6'd0, kc}) begin
      job.status = mvconv_pkg::ST_POS;
    end else begin
      job.status = mvconv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels <= 3'd1;
      image_rows <= 7'd64;
      image_cols <= 7'd64;
      kernel_rows <= 4'd3;
      kernel_cols <= 4'd3;
      bias <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mvconv_pkg::REG_CHANNELS: channels <= cfg_data[2:0];
        mvconv_pkg::REG_IMAGE_ROWS: image_rows <= cfg_data[6:0];
        mvconv_pkg::REG_IMAGE_COLS: image_cols <= cfg_data[6:0];
        mvconv_pkg::REG_KERNEL_ROWS: kernel_rows <= cfg_data[3:0];
        mvconv_pkg::REG_KERNEL_COLS: kernel_cols <= cfg_data[3:0];
        mvconv_pkg::REG_BIAS: bias <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/mvconv_back.sv */
// Back end: stores, multiply-accumulate walk and result register.
`default_nettype none
module mvconv_back #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_IMAGE_DIM = 64,
  parameter int MAX_KERNEL_DIM = 8
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic wr_en,
  input wire mvconv_pkg::in_item_t wr_item,
  input wire logic job_valid,
  input wire mvconv_pkg::job_t job,
  output logic job_pop,
  output logic busy,
  input wire logic [4:0] nch,
  input wire logic [4:0] kr,
  input wire logic [4:0] kc,
  input wire logic signed [31:0] bias,
  output logic res_valid,
  output mvconv_pkg::out_item_t res,
  input wire logic res_pop
);
  localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IdW = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;
  localparam int KdW = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
  localparam int ImgA = ChW + 2 * IdW;
  localparam int WgtA = ChW + 2 * KdW;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN1, S_DRAIN2, S_OUT} state_t;
  state_t state;

  logic signed [15:0] image_mem [2**ImgA];
  logic signed [15:0] weight_mem [2**WgtA];
  logic signed [15:0] s_rd, w_rd;
  logic signed [31:0] prod;
  logic signed [47:0] acc;
  logic [1:0] res_status;
  logic [ChW-1:0] k;
  logic [KdW-1:0] i, j;
  logic [IdW-1:0] r0, c0;
  logic rd_v, mul_v, prod_v, last;
  logic [IdW:0] ri, cj;

  // Write side; writes beyond the physical store are dropped.
  always_ff @(posedge clk) begin
    if (wr_en && wr_item.command == mvconv_pkg::CMD_WEIGHT
        && int'(wr_item.channel) < MAX_CHANNELS
        && int'(wr_item.row) < MAX_KERNEL_DIM && int'(wr_item.col) < MAX_KERNEL_DIM) begin
      weight_mem[{ChW'(wr_item.channel), KdW'(wr_item.row), KdW'(wr_item.col)}]
        <= wr_item.value;
    end
    if (wr_en && wr_item.command == mvconv_pkg::CMD_SAMPLE
        && int'(wr_item.channel) < MAX_CHANNELS
        && int'(wr_item.row) < MAX_IMAGE_DIM && int'(wr_item.col) < MAX_IMAGE_DIM) begin
      image_mem[{ChW'(wr_item.channel), IdW'(wr_item.row), IdW'(wr_item.col)}]
        <= wr_item.value;
    end
  end

  assign ri = {1'b0, r0} + (IdW + 1)'(i);
  assign cj = {1'b0, c0} + (IdW + 1)'(j);
  assign last = ({1'b0, k} == (ChW + 1)'(nch - 5'd1))
                && ({1'b0, i} == (KdW + 1)'(kr - 5'd1))
                && ({1'b0, j} == (KdW + 1)'(kc - 5'd1));

  always_ff @(posedge clk) begin
    s_rd <= image_mem[{k, ri[IdW-1:0], cj[IdW-1:0]}];
    w_rd <= weight_mem[{k, i, j}];
    prod <= s_rd * w_rd;
  end

  assign job_pop = state == S_IDLE && job_valid;
  assign res_valid = state == S_OUT;
  assign busy = state == S_RUN;

  // The read data and then the product are registered: s_rd and w_rd from the address, prod from the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v <= 1'b0;
      mul_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      mul_v <= rd_v;
      prod_v <= mul_v;
      if (prod_v) acc <= acc + 48'(prod);
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            r0 <= IdW'(job.row);
            c0 <= IdW'(job.col);
            k <= '0;
            i <= '0;
            j <= '0;
            res_status <= job.status;
            if (job.status == mvconv_pkg::ST_OK) begin
              acc <= 48'(bias);
              rd_v <= 1'b1;
              state <= S_RUN;
            end else begin
              acc <= '0;
              state <= S_OUT;
            end
          end
        end
        S_RUN: begin
          if (last) begin
            rd_v <= 1'b0;
            state <= S_DRAIN1;
          end else if ({1'b0, j} == (KdW + 1)'(kc - 5'd1)) begin
            j <= '0;
            if ({1'b0, i} == (KdW + 1)'(kr - 5'd1)) begin
              i <= '0;
              k <= k + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: if (!mul_v) state <= S_OUT;
        S_OUT: if (res_pop) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res = '{sum: acc, status: res_status};

  a_out_not_running: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !rd_v && !mul_v && !prod_v)
    else $error("result shown while products pending");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != mvconv_pkg::ST_OK |-> res.sum == '0)
    else $error("error result has nonzero sum");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> state != S_IDLE) else $error("job taken without leaving idle");
endmodule
`default_nettype wire

/* src/mvconv_jobq.sv */
// Two-entry queue of compute jobs between front and back.
`default_nettype none
module mvconv_jobq (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire mvconv_pkg::job_t din,
  output logic full,
  output logic valid,
  output mvconv_pkg::job_t dout,
  input wire logic pop
);
  mvconv_pkg::job_t q [2];
  logic rp, wp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign valid = cnt != 2'd0;
  assign dout = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= din;
    if (rst) begin
      rp <= 1'b0;
      wp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* src/multichannel_valid_conv2d.sv */
// Top level of the multichannel valid-mode 2-D correlator with bias.
//
//  channel | handshake          | payload
//  in      | push / full        | in (command, channel, row, col, value)
//  out     | pop / empty        | out (sum, status)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A compute walks channels*kernel_rows*kernel_cols steps of multiply-accumulate
// (one store read pair per cycle), then drains through the product and accumulator.
// An error compute skips the walk. Reset clears control and registers only; the
// stores hold garbage until written. Up to two jobs queue while the back end is busy
// or its result waits; computes stall (full) only when that queue is full, and
// writes also stall while a compute is queued or still reading the stores.
`default_nettype none
module multichannel_valid_conv2d #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_IMAGE_DIM = 64,
  parameter int MAX_KERNEL_DIM = 8
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire mvconv_pkg::in_item_t in,
  output logic empty,
  input wire logic pop,
  output mvconv_pkg::out_item_t out,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [2:0] cfg_index,
  input wire logic [31:0] cfg_data
);
  logic jq_full, jq_valid, job_pop, job_push, res_valid;
  logic back_busy, store_busy;
  mvconv_pkg::job_t job_in, job_out;
  logic [4:0] nch, kr, kc;
  logic signed [31:0] bias;

  assign cfg_ready = 1'b1;
  assign empty = !res_valid;
  assign store_busy = jq_valid || back_busy;

  mvconv_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_IMAGE_DIM(MAX_IMAGE_DIM),
    .MAX_KERNEL_DIM(MAX_KERNEL_DIM)) u_front (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .in_push(push), .in_item(in),
    .job_full(jq_full), .store_busy, .full, .job_push, .job(job_in), .nch, .kr, .kc,
    .bias);

  mvconv_jobq u_jobq (.clk, .rst, .push(job_push), .din(job_in), .full(jq_full),
    .valid(jq_valid), .dout(job_out), .pop(job_pop));

  mvconv_back #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_IMAGE_DIM(MAX_IMAGE_DIM),
    .MAX_KERNEL_DIM(MAX_KERNEL_DIM)) u_back (
    .clk, .rst, .wr_en(push && !full), .wr_item(in), .job_valid(jq_valid),
    .job(job_out), .job_pop, .busy(back_busy), .nch, .kr, .kc, .bias, .res_valid,
    .res(out), .res_pop(pop));
endmodule
`default_nettype wire
